// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RRTD_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRTD_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rrtd_pkg.sv
// ---------------------------------------------------------------------------
// rrtd_pkg
// Types, sizes and helpers shared by the round-robin task dispatcher.
// ---------------------------------------------------------------------------
package rrtd_pkg;

  localparam int NUM_WORKERS = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int WRK_W   = $clog2(NUM_WORKERS);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int GCNT_W  = $clog2(NUM_WORKERS * QUEUE_DEPTH + 1);
  localparam int MEM_AW  = WRK_W + PTR_W;
  localparam int MEM_DEPTH = NUM_WORKERS * (2 ** PTR_W);
  localparam int MEM_W   = 64;

  localparam int LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam int CMP_W   = (GCNT_W > LIMIT_W) ? GCNT_W : LIMIT_W;

  typedef enum logic [2:0] {
    ST_SUBMITTED = 3'd0,
    ST_LIMIT     = 3'd1,
    ST_FULL      = 3'd2,
    ST_FETCHED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    MODE_SUBMIT = 1'b0,
    MODE_FETCH  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  worker_id;
    logic [31:0] task_handle;
    logic [31:0] task_argument;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  worker_index;
    logic [31:0] out_handle;
    logic [31:0] out_argument;
    logic [4:0]  worker_pending;
    logic [6:0]  total_pending;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic load_fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fetch_hit;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// File: hdl/round_robin_task_dispatcher_unit.sv
// Submit, rejected submit and empty fetch strobe once the evaluate step registers the result;
// a fetch that pops a task strobes after the evaluate step and the registered store read.
// Busy covers the evaluate step and the store read, so no new item is taken before the
// last one is through; a new item is taken during the strobe.
// Reset: synchronous, active low; all queues empty, pointer at worker 0, limit 64.
// ---------------------------------------------------------------------------
// round_robin_task_dispatcher_unit
// Round-robin submit into per-worker ring queues, fetch by worker, with limit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_task_dispatcher_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rrtd_pkg::item_t              in_item,
  output logic                         out_valid,
  output rrtd_pkg::result_t            out_result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rrtd_pkg::LIMIT_W-1:0] cfg_data
);

  rrtd_pkg::ctrl_cmd_t cmd;
  rrtd_pkg::dp_stat_t  stat;
  logic                cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  rrtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid)
  );

  rrtd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_result (out_result)
  );

  `RRTD_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_valid,
    "accepted beat did not start work")
  `RRTD_ASSERT_IMP(a_strobe_after_work, out_valid, $past(busy) && !busy,
    "result strobe without preceding work")
  `RRTD_ASSERT_IMP(a_zero_payload, out_valid && out_result.status != rrtd_pkg::ST_FETCHED,
    out_result.out_handle == '0 && out_result.out_argument == '0,
    "nonzero task payload on a non-fetch result")
  `RRTD_ASSERT_IMP(a_total_bound, out_valid,
    out_result.total_pending <= 7'(rrtd_pkg::NUM_WORKERS * rrtd_pkg::QUEUE_DEPTH),
    "total pending beyond queue capacity")

endmodule

// File: hdl/rrtd_ram.sv
// ---------------------------------------------------------------------------
// rrtd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rrtd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rrtd_ctrl.sv
// ---------------------------------------------------------------------------
// rrtd_ctrl
// Sequencer: accept, evaluate, optional queue read, then strobe the result.
// ---------------------------------------------------------------------------
module rrtd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rrtd_pkg::dp_stat_t   stat,
  output rrtd_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 cfg_ready,
  output logic                 out_valid
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.fetch_hit ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd.load_fetch = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (cmd.eval && !stat.fetch_hit) || cmd.load_fetch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;

endmodule

// File: hdl/rrtd_dp.sv
// ---------------------------------------------------------------------------
// rrtd_dp
// Queue pointers, counters, round-robin pointer, task store and result register.
// ---------------------------------------------------------------------------
module rrtd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrtd_pkg::ctrl_cmd_t          cmd,
  output rrtd_pkg::dp_stat_t           stat,
  input  rrtd_pkg::item_t              in_item,
  input  logic                         cfg_we,
  input  logic [rrtd_pkg::LIMIT_W-1:0] cfg_data,
  output rrtd_pkg::result_t            out_result
);

  localparam int NW  = rrtd_pkg::NUM_WORKERS;
  localparam int WW  = rrtd_pkg::WRK_W;
  localparam int PW  = rrtd_pkg::PTR_W;
  localparam int CW  = rrtd_pkg::CNT_W;
  localparam int GW  = rrtd_pkg::GCNT_W;
  localparam int AW  = rrtd_pkg::MEM_AW;
  localparam int DW  = rrtd_pkg::MEM_W;

  rrtd_pkg::item_t            item_r, item_nxt;
  rrtd_pkg::result_t          res_r, res_nxt;
  logic [WW-1:0]              rr_r, rr_nxt;
  logic [PW-1:0]              head_r [NW];
  logic [PW-1:0]              head_nxt [NW];
  logic [PW-1:0]              tail_r [NW];
  logic [PW-1:0]              tail_nxt [NW];
  logic [CW-1:0]              cnt_r [NW];
  logic [CW-1:0]              cnt_nxt [NW];
  logic [GW-1:0]              glob_r, glob_nxt;
  logic [rrtd_pkg::LIMIT_W-1:0] limit_r, limit_nxt;

  logic          is_fetch;
  logic          wid_ok;
  logic [WW-1:0] w;
  logic [CW-1:0] cnt_w;
  logic          limit_hit;
  logic          full_hit;
  logic          empty_hit;
  logic [WW-1:0] rr_adv;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  assign is_fetch  = (item_r.mode == rrtd_pkg::MODE_FETCH);
  assign wid_ok    = int'(item_r.worker_id) < NW;
  assign w         = is_fetch ? WW'(item_r.worker_id) : rr_r;
  assign cnt_w     = cnt_r[w];
  assign limit_hit = rrtd_pkg::CMP_W'(glob_r) >= rrtd_pkg::CMP_W'(limit_r);
  assign full_hit  = (cnt_w == CW'(rrtd_pkg::QUEUE_DEPTH));
  assign empty_hit = !wid_ok || (cnt_w == '0);
  assign rr_adv    = (rr_r == WW'(NW - 1)) ? '0 : rr_r + 1'b1;
  assign stat.fetch_hit = is_fetch && !empty_hit;

  always_comb begin
    item_nxt  = item_r;
    res_nxt   = res_r;
    rr_nxt    = rr_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    glob_nxt  = glob_r;
    limit_nxt = limit_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = {w, tail_r[w]};
    ram_raddr = {w, head_r[w]};

    if (cmd.load_item) begin
      item_nxt = in_item;
    end
    if (cfg_we) begin
      limit_nxt = cfg_data;
    end

    if (cmd.eval) begin
      res_nxt.out_handle     = '0;
      res_nxt.out_argument   = '0;
      res_nxt.worker_pending = 5'(cnt_w);
      res_nxt.total_pending  = 7'(glob_r);
      if (!is_fetch) begin
        res_nxt.worker_index = 2'(w);
        if (limit_hit) begin
          res_nxt.status = rrtd_pkg::ST_LIMIT;
        end else begin
          rr_nxt = rr_adv;
          if (full_hit) begin
            res_nxt.status = rrtd_pkg::ST_FULL;
          end else begin
            ram_we                 = 1'b1;
            tail_nxt[w]            = rrtd_pkg::ring_next(tail_r[w]);
            cnt_nxt[w]             = cnt_w + 1'b1;
            glob_nxt               = glob_r + 1'b1;
            res_nxt.status         = rrtd_pkg::ST_SUBMITTED;
            res_nxt.worker_pending = 5'(cnt_w + 1'b1);
            res_nxt.total_pending  = 7'(glob_r + 1'b1);
          end
        end
      end else begin
        res_nxt.worker_index = item_r.worker_id;
        if (empty_hit) begin
          res_nxt.status         = rrtd_pkg::ST_EMPTY;
          res_nxt.worker_pending = '0;
        end else begin
          ram_re                 = 1'b1;
          head_nxt[w]            = rrtd_pkg::ring_next(head_r[w]);
          cnt_nxt[w]             = cnt_w - 1'b1;
          res_nxt.status         = rrtd_pkg::ST_FETCHED;
          res_nxt.worker_pending = 5'(cnt_w - 1'b1);
          if (glob_r != '0) begin
            glob_nxt              = glob_r - 1'b1;
            res_nxt.total_pending = 7'(glob_r - 1'b1);
          end
        end
      end
    end

    if (cmd.load_fetch) begin
      res_nxt.out_handle   = ram_rdata[DW-1:DW/2];
      res_nxt.out_argument = ram_rdata[DW/2-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r    <= '0;
      glob_r  <= '0;
      limit_r <= rrtd_pkg::LIMIT_RESET;
      for (int i = 0; i < NW; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      rr_r    <= rr_nxt;
      glob_r  <= glob_nxt;
      limit_r <= limit_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  rrtd_ram #(
    .WIDTH (DW),
    .DEPTH (rrtd_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item_r.task_handle, item_r.task_argument}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_result = res_r;

endmodule
